// ===== design/tes_pkg.sv =====
// Package for the touch event to sample decoder: event codes, register indexes,
// and the structs that travel between the decoder's modules. No dependencies.
package tes_pkg;

  // Event types
  localparam logic [15:0] EVT_SYN = 16'h0000;
  localparam logic [15:0] EVT_KEY = 16'h0001;
  localparam logic [15:0] EVT_ABS = 16'h0003;

  // Sync codes
  localparam logic [15:0] SYN_RPT    = 16'h0000;
  localparam logic [15:0] SYN_MT_RPT = 16'h0002;

  // Key codes that mean pen contact
  localparam logic [15:0] KEY_LEFT  = 16'h0110;
  localparam logic [15:0] KEY_TOUCH = 16'h014A;

  // Absolute axis codes
  localparam logic [15:0] ABS_X        = 16'h0000;
  localparam logic [15:0] ABS_Y        = 16'h0001;
  localparam logic [15:0] ABS_X_ALT    = ABS_X + 16'd2;
  localparam logic [15:0] ABS_Y_ALT    = ABS_Y + 16'd2;
  localparam logic [15:0] ABS_PRESS    = 16'h0018;
  localparam logic [15:0] ABS_MT_X     = 16'h0035;
  localparam logic [15:0] ABS_MT_Y     = 16'h0036;
  localparam logic [15:0] ABS_MT_DIST  = 16'h003B;

  localparam logic [31:0] FULL_PRESS = 32'd255;
  localparam logic [7:0]  COUNT_MAX  = 8'd255;

  // Device variants
  localparam logic [1:0] VAR_SHIFTED  = 2'd1;
  localparam logic [1:0] VAR_DISTANCE = 2'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_VAR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_ABSENT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_A_START = 8'd3;

  typedef struct packed {
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic [31:0] event_value;
    logic [63:0] event_time;
  } event_t;

  typedef struct packed {
    logic [31:0] sample_x;
    logic [31:0] sample_y;
    logic [31:0] sample_pressure;
    logic [63:0] sample_time;
  } sample_t;

  typedef struct packed {
    logic       emit;
    sample_t    sample;
  } result_t;

  typedef struct packed {
    logic       sync_mode;
    logic [1:0] device_variant;
  } cfg_t;

  // Side effects of a register write on the tracking state
  typedef struct packed {
    logic press_load;
    logic count_load;
    logic count_val;
  } cfg_load_t;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] press;
    logic        pen_lifted;
    logic [7:0]  type_a_count;
  } state_t;

endpackage

// ===== design/tes_if.sv =====
// Handshake interfaces for the event, sample and configuration channels.
// Depends on tes_pkg for the configuration port widths.
interface tes_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_type;
  logic [15:0] event_code;
  logic signed [31:0] event_value;
  logic [63:0] event_time;

  modport source (output valid, event_type, event_code, event_value, event_time,
                  input ready);
  modport sink (input valid, event_type, event_code, event_value, event_time,
                output ready);
endinterface

interface tes_sample_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] sample_pressure;
  logic [63:0] sample_time;

  modport source (output valid, sample_x, sample_y, sample_pressure, sample_time,
                  input ready);
  modport sink (input valid, sample_x, sample_y, sample_pressure, sample_time,
                output ready);
endinterface

interface tes_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tes_pkg::CFG_IDX_W-1:0]  index;
  logic [tes_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/touch_event_to_sample.sv =====
// Top level of the touch event to sample decoder: input register, decoder,
// state registers and sample register. Depends on tes_pkg, tes_if, tes_cfg, tes_decode.
//
// Usage:
//   event_i  - sink channel of input events (type, code, value, time).
//   sample_o - source channel of samples (x, y, pressure, time).
//   cfg_i    - register writes, index 0 sync_mode, 1 device_variant,
//              2 pressure-absent flag, 3 type_a_start; other indexes are ignored.
//              Always ready; write only while no event is in flight.
// Timing: an accepted event is decoded from the event register, and its
//   sample, if any, is loaded into the sample register when the event advances.
// Throughput: one event per cycle unless sample_o stalls. The event register
//   and the sample register are separate stages, so a new event is taken while
//   a finished sample still waits to be taken.
// Stall: while sample_o is held off with a sample pending, the event stage
//   holds its item and event_i.ready drops once that stage is full.
// Reset: clears both stages, x, y, pressure and pen-up to zero, the
//   counter to zero, and the registers to sync mode, generic variant.
module touch_event_to_sample (
  input  logic         clk_i,
  input  logic         rst_ni,
  tes_event_if.sink    event_i,
  tes_sample_if.source sample_o,
  tes_cfg_if.sink      cfg_i
);
  import tes_pkg::*;

  cfg_t      cfg;
  cfg_load_t cfg_load;
  state_t    state_q, state_d, state_dec;
  result_t   result;
  event_t    ev_q;
  sample_t   sample_q;
  logic      ev_valid_q;
  logic      out_valid_q;
  logic      advance;

  tes_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .load_o (cfg_load)
  );

  tes_decode u_decode (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .event_i  (ev_q),
    .state_o  (state_dec),
    .result_o (result)
  );

  // Advance the held event when the sample register is free or draining.
  assign advance       = ev_valid_q && (!out_valid_q || sample_o.ready);
  assign event_i.ready = !ev_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (event_i.ready) begin
      ev_valid_q <= event_i.valid;
    end
  end

  // Event payload needs no reset; capture on accept only.
  always_ff @(posedge clk_i) begin
    if (event_i.valid && event_i.ready) begin
      ev_q.event_type  <= event_i.event_type;
      ev_q.event_code  <= event_i.event_code;
      ev_q.event_value <= event_i.event_value;
      ev_q.event_time  <= event_i.event_time;
    end
  end

  // Tracking state; a register write's load wins over the decoder.
  always_comb begin
    state_d = state_q;
    if (advance) state_d = state_dec;
    if (cfg_load.press_load) state_d.press = FULL_PRESS;
    if (cfg_load.count_load) state_d.type_a_count = {7'd0, cfg_load.count_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.emit;
    end else if (sample_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) sample_q <= result.sample;
  end

  assign sample_o.valid           = out_valid_q;
  assign sample_o.sample_x        = sample_q.sample_x;
  assign sample_o.sample_y        = sample_q.sample_y;
  assign sample_o.sample_pressure = sample_q.sample_pressure;
  assign sample_o.sample_time     = sample_q.sample_time;

  // A sync report clears the pen-up flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cfg.sync_mode && ev_q.event_type == EVT_SYN &&
    ev_q.event_code == SYN_RPT |=> !state_q.pen_lifted)
    else $error("pen_lifted not cleared by sync report");

  // A sync report after a pen-up gives zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cfg.sync_mode && ev_q.event_type == EVT_SYN &&
    ev_q.event_code == SYN_RPT && state_q.pen_lifted
    |=> out_valid_q && sample_q.sample_pressure == 32'd0)
    else $error("pen-up sample with nonzero pressure");

  // Raw mode never touches the pen-up flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg.sync_mode |=> $stable(state_q.pen_lifted))
    else $error("raw mode changed pen_lifted");

  // A pending sample is never overwritten while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !sample_o.ready |-> !advance)
    else $error("event advanced over a stalled sample");

endmodule

// ===== design/tes_cfg.sv =====
// Configuration registers of the touch event decoder, with the state loads
// that a write of the pressure-absent flag or type_a_start causes.
// Depends on tes_pkg, tes_if.
module tes_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tes_cfg_if.sink              cfg_i,
  output tes_pkg::cfg_t        cfg_o,
  output tes_pkg::cfg_load_t   load_o
);
  import tes_pkg::*;

  logic       sync_mode_q;
  logic [1:0] device_variant_q;
  logic       press_absent_q;
  logic       type_a_start_q;
  logic       wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode_q      <= 1'b1;
      device_variant_q <= 2'd0;
      press_absent_q   <= 1'b0;
      type_a_start_q   <= 1'b0;
    end else if (wr) begin
      case (cfg_i.index)
        REG_SYNC_MODE:    sync_mode_q      <= cfg_i.data[0];
        REG_DEVICE_VAR:   device_variant_q <= cfg_i.data[1:0];
        REG_PRESS_ABSENT: press_absent_q   <= cfg_i.data[0];
        REG_TYPE_A_START: type_a_start_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.sync_mode      = sync_mode_q;
  assign cfg_o.device_variant = device_variant_q;

  // Writing the pressure-absent flag as 1 loads full pressure; writing
  // type_a_start reloads the counter. press_absent_q only records the setting.
  always_comb begin
    load_o.press_load = wr && (cfg_i.index == REG_PRESS_ABSENT) && cfg_i.data[0];
    load_o.count_load = wr && (cfg_i.index == REG_TYPE_A_START);
    load_o.count_val  = cfg_i.data[0] | (type_a_start_q & 1'b0) | (press_absent_q & 1'b0);
  end

endmodule

// ===== design/tes_decode.sv =====
// Event decoder: next tracking state and the optional sample for one event.
// Pure combinational logic. Depends on tes_pkg.
module tes_decode (
  input  tes_pkg::cfg_t    cfg_i,
  input  tes_pkg::state_t  state_i,
  input  tes_pkg::event_t  event_i,
  output tes_pkg::state_t  state_o,
  output tes_pkg::result_t result_o
);
  import tes_pkg::*;

  logic        pen_key;
  logic        val_zero;
  logic        val_pos;
  logic [7:0]  count_inc;
  logic [15:0] code;
  logic [31:0] val;

  assign code      = event_i.event_code;
  assign val       = event_i.event_value;
  assign pen_key   = (code == KEY_TOUCH) || (code == KEY_LEFT);
  assign val_zero  = (val == 32'd0);
  assign val_pos   = !val[31] && !val_zero;
  assign count_inc = (state_i.type_a_count != COUNT_MAX) ?
                     state_i.type_a_count + 8'd1 : state_i.type_a_count;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.sample.sample_time = event_i.event_time;
    if (cfg_i.sync_mode) begin
      case (event_i.event_type)
        EVT_KEY: begin
          if (pen_key && val_zero) state_o.pen_lifted = 1'b1;
        end
        EVT_SYN: begin
          if (code == SYN_RPT) begin
            result_o.emit = 1'b1;
            result_o.sample.sample_x = state_i.x_pos;
            result_o.sample.sample_y = state_i.y_pos;
            result_o.sample.sample_pressure = state_i.pen_lifted ? 32'd0 : state_i.press;
            state_o.pen_lifted = 1'b0;
          end else if (code == SYN_MT_RPT) begin
            if (state_i.type_a_count == 8'd1) state_o.pen_lifted = 1'b1;
            else if (state_i.type_a_count != 8'd0) state_o.type_a_count = 8'd1;
          end
        end
        EVT_ABS: begin
          case (cfg_i.device_variant)
            VAR_SHIFTED: begin
              if (code == ABS_X_ALT) state_o.x_pos = val;
              else if (code == ABS_Y_ALT) state_o.y_pos = val;
              else if (code == ABS_PRESS) state_o.press = val;
            end
            VAR_DISTANCE: begin
              if (code == ABS_X) state_o.x_pos = val;
              else if (code == ABS_Y) state_o.y_pos = val;
              else if (code == ABS_PRESS) state_o.press = val;
              else if (code == ABS_MT_DIST) state_o.press = val_pos ? 32'd0 : FULL_PRESS;
            end
            default: begin
              if (code == ABS_X) state_o.x_pos = val;
              else if (code == ABS_Y) state_o.y_pos = val;
              else if (code == ABS_MT_X) begin
                state_o.x_pos = val;
                state_o.type_a_count = count_inc;
              end else if (code == ABS_MT_Y) begin
                state_o.y_pos = val;
                state_o.type_a_count = count_inc;
              end else if (code == ABS_PRESS) state_o.press = val;
            end
          endcase
        end
        default: ;
      endcase
    end else begin
      // Raw mode: emit on x, y, pressure and pen-up events; pen_lifted and the counter stay.
      if (event_i.event_type == EVT_ABS) begin
        if (code == ABS_X && !val_zero) begin
          state_o.x_pos = val;
          result_o.emit = 1'b1;
        end else if (code == ABS_Y && !val_zero) begin
          state_o.y_pos = val;
          result_o.emit = 1'b1;
        end else if (code == ABS_PRESS) begin
          state_o.press = val;
          result_o.emit = 1'b1;
        end
        result_o.sample.sample_x        = state_o.x_pos;
        result_o.sample.sample_y        = state_o.y_pos;
        result_o.sample.sample_pressure = state_o.press;
      end else if (event_i.event_type == EVT_KEY && pen_key && val_zero) begin
        result_o.emit = 1'b1;
      end
    end
  end

endmodule

// ===== dv/touch_event_to_sample_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for touch_event_to_sample: a directed table, then random
// event streams over many register settings. Depends on tes_pkg, tes_if and the design.
module touch_event_to_sample_tb;
  import tes_pkg::*;

  localparam int unsigned IDLE_PCT       = 11;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned MAX_PRINTS     = 40;
  localparam longint unsigned TIMEOUT_NS = 1_000_000;

  // Register values that have no name in the package
  localparam logic [1:0] VAR_GENERIC = 2'd0;
  localparam logic [1:0] VAR_SPARE   = 2'd3;
  localparam logic       MODE_RAW    = 1'b0;
  localparam logic       MODE_SYNC   = 1'b1;

  typedef enum logic [1:0] {ROW_EVENT, ROW_LIT, ROW_CFG} row_kind_e;

  // One line of the directed table: a register write, or an event whose
  // sample is either predicted or typed in
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    event_t                 ev;
    sample_t                lit;
  } stim_row_t;

  typedef struct packed {
    logic    on;
    sample_t smp;
  } typed_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tes_event_if  ev_if ();
  tes_sample_if smp_if ();
  tes_cfg_if    cfg_if ();

  touch_event_to_sample u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .event_i  (ev_if),
    .sample_o (smp_if),
    .cfg_i    (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the registers and the tracking state
  logic        reg_sync;
  logic [1:0]  reg_variant;
  logic        reg_nopress;
  logic        reg_typea;
  logic [31:0] track_x;
  logic [31:0] track_y;
  logic [31:0] track_press;
  logic        track_pen_up;
  logic [7:0]  track_count;

  sample_t       expected_samples [$];
  typed_sample_t typed_samples [$];
  stim_row_t     directed_rows [$];

  int unsigned mismatch_count;
  int unsigned samples_checked;
  int unsigned events_sent;
  int unsigned writes_done;
  int unsigned directed_events;

  bit steady_run;
  bit holdoff_req;
  bit holdoff_done;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  task automatic reset_model();
    reg_sync     = MODE_SYNC;
    reg_variant  = VAR_GENERIC;
    reg_nopress  = 1'b0;
    reg_typea    = 1'b0;
    track_x      = '0;
    track_y      = '0;
    track_press  = '0;
    track_pen_up = 1'b0;
    track_count  = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SYNC_MODE:  reg_sync = data[0];
      REG_DEVICE_VAR: reg_variant = data[1:0];
      REG_PRESS_ABSENT: begin
        reg_nopress = data[0];
        if (data[0]) track_press = FULL_PRESS;
      end
      REG_TYPE_A_START: begin
        reg_typea   = data[0];
        track_count = {7'd0, data[0]};
      end
      default: ;
    endcase
  endtask

  task automatic bump_count();
    if (track_count != COUNT_MAX) track_count = track_count + 8'd1;
  endtask

  // Advance the tracking state by one event; raise got when it yields a sample
  task automatic predict_sample(input event_t ev, output logic got, output sample_t smp);
    logic        pen_key;
    logic [15:0] code;
    logic [31:0] v;
    code    = ev.event_code;
    v       = ev.event_value;
    pen_key = (code == KEY_TOUCH) || (code == KEY_LEFT);
    got     = 1'b0;
    smp     = '0;
    if (reg_sync) begin
      if (ev.event_type == EVT_KEY) begin
        if (pen_key && v == 32'd0) track_pen_up = 1'b1;
      end else if (ev.event_type == EVT_SYN) begin
        if (code == SYN_RPT) begin
          got = 1'b1;
          smp = '{track_x, track_y, track_pen_up ? 32'd0 : track_press, ev.event_time};
          track_pen_up = 1'b0;
        end else if (code == SYN_MT_RPT) begin
          if (track_count == 8'd1) track_pen_up = 1'b1;
          else if (track_count != 8'd0) track_count = 8'd1;
        end
      end else if (ev.event_type == EVT_ABS) begin
        case (reg_variant)
          VAR_SHIFTED: begin
            if (code == ABS_X_ALT) track_x = v;
            else if (code == ABS_Y_ALT) track_y = v;
            else if (code == ABS_PRESS) track_press = v;
          end
          VAR_DISTANCE: begin
            if (code == ABS_X) track_x = v;
            else if (code == ABS_Y) track_y = v;
            else if (code == ABS_PRESS) track_press = v;
            else if (code == ABS_MT_DIST) track_press = ($signed(v) > 32'sd0) ? 32'd0 : FULL_PRESS;
          end
          default: begin
            if (code == ABS_X) track_x = v;
            else if (code == ABS_Y) track_y = v;
            else if (code == ABS_MT_X) begin
              track_x = v;
              bump_count();
            end else if (code == ABS_MT_Y) begin
              track_y = v;
              bump_count();
            end else if (code == ABS_PRESS) track_press = v;
          end
        endcase
      end
    end else begin
      if (ev.event_type == EVT_ABS) begin
        // Zero x or y is dropped; axes other than x, y and pressure give nothing in raw mode
        if (code == ABS_X && v != 32'd0) begin
          track_x = v;
          got = 1'b1;
        end else if (code == ABS_Y && v != 32'd0) begin
          track_y = v;
          got = 1'b1;
        end else if (code == ABS_PRESS) begin
          track_press = v;
          got = 1'b1;
        end
        if (got) smp = '{track_x, track_y, track_press, ev.event_time};
      end else if (ev.event_type == EVT_KEY && pen_key && v == 32'd0) begin
        got = 1'b1;
        smp = '{32'd0, 32'd0, 32'd0, ev.event_time};
      end
    end
  endtask

  // Predict on every accepted event, compare every accepted sample
  always @(posedge clk_i) begin : scoreboard
    event_t        ev;
    sample_t       pred;
    sample_t       want;
    typed_sample_t typed;
    logic          got;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_if.valid && cfg_if.ready) apply_write(cfg_if.index, cfg_if.data);
      if (ev_if.valid && ev_if.ready) begin
        ev.event_type  = ev_if.event_type;
        ev.event_code  = ev_if.event_code;
        ev.event_value = ev_if.event_value;
        ev.event_time  = ev_if.event_time;
        typed = '0;
        if (typed_samples.size() != 0) typed = typed_samples.pop_front();
        predict_sample(ev, got, pred);
        // A typed-in row overrides the prediction but still moves the state
        if (typed.on) expected_samples.push_back(typed.smp);
        else if (got) expected_samples.push_back(pred);
      end
      if (smp_if.valid && smp_if.ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample x=%h y=%h p=%h t=%h", smp_if.sample_x,
                                  smp_if.sample_y, smp_if.sample_pressure, smp_if.sample_time));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (smp_if.sample_x !== want.sample_x)
            flag_mismatch($sformatf("sample_x %h, want %h", smp_if.sample_x, want.sample_x));
          if (smp_if.sample_y !== want.sample_y)
            flag_mismatch($sformatf("sample_y %h, want %h", smp_if.sample_y, want.sample_y));
          if (smp_if.sample_pressure !== want.sample_pressure)
            flag_mismatch($sformatf("sample_pressure %h, want %h", smp_if.sample_pressure,
                                    want.sample_pressure));
          if (smp_if.sample_time !== want.sample_time)
            flag_mismatch($sformatf("sample_time %h, want %h", smp_if.sample_time,
                                    want.sample_time));
        end
      end
    end
  end

  // Sample receiver: random stalls, one long counted hold-off on request
  initial begin : sample_sink
    int unsigned n;
    smp_if.ready = 1'b0;
    holdoff_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req && !holdoff_done) begin
        smp_if.ready <= 1'b0;
        for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clk_i);
        holdoff_done = 1'b1;
        smp_if.ready <= 1'b1;
      end else begin
        smp_if.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic stim_row_t ev_row(input logic [15:0] typ, input logic [15:0] code,
                                       input logic [31:0] v, input logic [63:0] t);
    stim_row_t r;
    r     = '0;
    r.kind = ROW_EVENT;
    r.ev  = '{typ, code, v, t};
    return r;
  endfunction

  function automatic stim_row_t lit_row(input logic [15:0] typ, input logic [15:0] code,
                                        input logic [63:0] t, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] p);
    stim_row_t r;
    r      = ev_row(typ, code, 32'd0, t);
    r.kind = ROW_LIT;
    r.lit  = '{x, y, p, t};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Random upper bits around the field a register keeps
  function automatic logic [31:0] noisy(input logic [31:0] val, input logic [31:0] mask);
    return ($urandom() & ~mask) | (val & mask);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'd0;
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
      2, 3: return 32'($urandom_range(1000));
      4: return 32'(-int'($urandom_range(1, 1000)));
      default: return $urandom();
    endcase
  endfunction

  // Mostly decodable events, with some keys, reports and plain noise
  function automatic event_t rand_event();
    event_t      e;
    int unsigned pick;
    pick          = $urandom_range(99);
    e.event_time  = {$urandom(), $urandom()};
    e.event_value = rand_value();
    if (pick < 35) begin
      e.event_type = EVT_ABS;
      case ($urandom_range(7))
        0: e.event_code = ABS_X;
        1: e.event_code = ABS_Y;
        2: e.event_code = ABS_X_ALT;
        3: e.event_code = ABS_Y_ALT;
        4: e.event_code = ABS_PRESS;
        5: e.event_code = ABS_MT_X;
        6: e.event_code = ABS_MT_Y;
        default: e.event_code = ABS_MT_DIST;
      endcase
    end else if (pick < 55) begin
      e.event_type = EVT_SYN;
      e.event_code = SYN_RPT;
    end else if (pick < 63) begin
      e.event_type = EVT_SYN;
      e.event_code = SYN_MT_RPT;
    end else if (pick < 78) begin
      e.event_type = EVT_KEY;
      e.event_code = $urandom_range(1) ? KEY_TOUCH : KEY_LEFT;
      if ($urandom_range(9) < 6) e.event_value = 32'd0;
    end else if (pick < 86) begin
      case ($urandom_range(2))
        0: e.event_type = EVT_KEY;
        1: e.event_type = EVT_SYN;
        default: e.event_type = EVT_ABS;
      endcase
      e.event_code = 16'($urandom_range(400));
    end else begin
      e.event_type = 16'($urandom());
      e.event_code = 16'($urandom());
    end
    return e;
  endfunction

  // Offer one event and hold it until taken; valid stays high for the next item
  task automatic send_event(input event_t ev, input typed_sample_t typed);
    if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    typed_samples.push_back(typed);
    ev_if.valid       <= 1'b1;
    ev_if.event_type  <= ev.event_type;
    ev_if.event_code  <= ev.event_code;
    ev_if.event_value <= ev.event_value;
    ev_if.event_time  <= ev.event_time;
    do @(posedge clk_i); while (!ev_if.ready);
    events_sent++;
  endtask

  task automatic send_random();
    send_event(rand_event(), '0);
  endtask

  // Drop valid, wait for every expected sample, then let the pipe run dry
  task automatic wait_idle();
    ev_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    writes_done++;
  endtask

  initial begin : stimulus
    stim_row_t   row;
    event_t      e;
    logic [2:0]  pbits;
    int unsigned phase;
    int unsigned i;
    int unsigned burst;
    int unsigned guard;

    rst_ni            = 1'b0;
    ev_if.valid       = 1'b0;
    ev_if.event_type  = '0;
    ev_if.event_code  = '0;
    ev_if.event_value = '0;
    ev_if.event_time  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    steady_run        = 1'b0;
    holdoff_req       = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset values, field extremes, pen-up, multitouch
    // reports, every variant, raw mode drops, masked and ignored writes
    directed_rows.push_back(lit_row(EVT_SYN, SYN_RPT, 64'd0, 32'd0, 32'd0, 32'd0));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_X, 32'h7FFF_FFFF, 64'd1));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_Y, 32'h8000_0000, 64'd2));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_PRESS, 32'hFFFF_FFFF, 64'd3));
    directed_rows.push_back(lit_row(EVT_SYN, SYN_RPT, 64'hFFFF_FFFF_FFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    directed_rows.push_back(ev_row(EVT_KEY, KEY_TOUCH, 32'd0, 64'd5));
    directed_rows.push_back(lit_row(EVT_SYN, SYN_RPT, 64'd6,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
    directed_rows.push_back(ev_row(EVT_KEY, KEY_LEFT, 32'd1, 64'd7));
    directed_rows.push_back(ev_row(EVT_KEY, KEY_LEFT, 32'd0, 64'd8));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd9));
    directed_rows.push_back(cfg_row(REG_TYPE_A_START, 32'd1));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_MT_RPT, 32'd0, 64'd10));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_MT_X, 32'd5, 64'd11));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_MT_Y, 32'd6, 64'd12));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_MT_RPT, 32'd0, 64'd13));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd14));
    directed_rows.push_back(cfg_row(REG_DEVICE_VAR, {30'd0, VAR_SHIFTED}));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_X_ALT, 32'd100, 64'd15));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_Y_ALT, 32'd200, 64'd16));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_X, 32'd7, 64'd17));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd18));
    directed_rows.push_back(cfg_row(REG_DEVICE_VAR, {30'd0, VAR_DISTANCE}));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_MT_DIST, 32'd1, 64'd19));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd20));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_MT_DIST, 32'hFFFF_FFFF, 64'd21));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd22));
    directed_rows.push_back(cfg_row(REG_DEVICE_VAR, {30'd0, VAR_SPARE}));
    directed_rows.push_back(cfg_row(REG_PRESS_ABSENT, 32'd1));
    directed_rows.push_back(cfg_row(REG_SYNC_MODE, {31'd0, MODE_RAW}));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_X, 32'd0, 64'd23));
    directed_rows.push_back(ev_row(EVT_ABS, ABS_Y, 32'd9, 64'd24));
    directed_rows.push_back(lit_row(EVT_KEY, KEY_TOUCH, 64'd25, 32'd0, 32'd0, 32'd0));
    directed_rows.push_back(ev_row(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'd26));
    directed_rows.push_back(cfg_row(8'hFF, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(REG_SYNC_MODE, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(REG_PRESS_ABSENT, 32'hFFFF_FFFE));
    directed_rows.push_back(cfg_row(REG_TYPE_A_START, 32'd0));
    directed_rows.push_back(cfg_row(REG_DEVICE_VAR, {30'd0, VAR_GENERIC}));
    directed_rows.push_back(ev_row(EVT_SYN, SYN_RPT, 32'd0, 64'd27));

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_event(row.ev, '{row.kind == ROW_LIT, row.lit});
        directed_events++;
      end
    end

    // Random phases: walk sync and raw mode over all four variant codes
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      pbits = 3'(phase);
      write_reg(REG_SYNC_MODE, noisy({31'd0, ~pbits[0]}, 32'd1));
      write_reg(REG_DEVICE_VAR, noisy({30'd0, pbits[2:1]}, 32'd3));
      write_reg(REG_PRESS_ABSENT, noisy({31'd0, pbits[0] ^ pbits[1]}, 32'd1));
      write_reg(REG_TYPE_A_START,
                noisy({31'd0, (phase == 0) || ($urandom_range(1) == 1)}, 32'd1));
      write_reg(8'($urandom_range(4, 255)), $urandom());
      steady_run  = (phase == 5);
      holdoff_req = (phase == 3);

      i = 0;
      if (phase == 0) begin
        // Drive the type-A counter into saturation, then report twice
        burst = 255 + $urandom_range(40);
        for (; i < burst; i++) begin
          e             = rand_event();
          e.event_type  = EVT_ABS;
          e.event_code  = $urandom_range(1) ? ABS_MT_X : ABS_MT_Y;
          send_event(e, '0);
        end
        repeat (2) begin
          e            = rand_event();
          e.event_type = EVT_SYN;
          e.event_code = SYN_MT_RPT;
          send_event(e, '0);
          e.event_code = SYN_RPT;
          send_event(e, '0);
          i += 2;
        end
      end
      for (; i < PHASE_ITEMS; i++) begin
        // Pause the sender mid-phase until every sample is home
        if (phase == 2 && i == PHASE_ITEMS / 2) wait_idle();
        send_random();
      end
    end

    ev_if.valid <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && expected_samples.size() != 0; guard++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_samples.size() != 0)
      flag_mismatch($sformatf("%0d expected samples never arrived", expected_samples.size()));

    $display("Run covered %0d events (%0d directed) and %0d register writes,",
             events_sent, directed_events, writes_done);
    $display("in sync and raw mode over all variant codes; %0d samples compared.",
             samples_checked);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: run did not complete");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== touch_event_to_sample.f =====
design/tes_pkg.sv
design/tes_if.sv
design/tes_cfg.sv
design/tes_decode.sv
design/touch_event_to_sample.sv
dv/touch_event_to_sample_tb.sv
